// ===== design/triangle_check_and_area_defines.svh =====
// Assertion helpers shared by the triangle block.
`ifndef TRIANGLE_CHECK_AND_AREA_DEFINES_SVH
`define TRIANGLE_CHECK_AND_AREA_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TCA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tca_pkg.sv =====
package tca_pkg;

    localparam int COORD_BITS    = 16;
    localparam int FRAC_BITS_DEF = 8;
    localparam int SLOPE_FRAC    = 16;
    localparam int AREA_FRAC     = 8;
    localparam int AREA_W        = 24;
    localparam int TOL_W         = 16;

    localparam int MAG_W  = COORD_BITS + 1;
    localparam int QUO_W  = MAG_W + SLOPE_FRAC;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SIDE_W = SQ_W / 2;
    localparam int TERM_W = SIDE_W + 2;
    localparam int P2_W   = 2 * TERM_W;
    localparam int PA_W   = P2_W + TERM_W;
    localparam int PROD_W = 4 * TERM_W;
    localparam int ROOT_W = PROD_W / 2;

    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_PAIR  = 2'd1,
        ST_ALL   = 2'd2,
        ST_LINE  = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_first;
        logic signed [COORD_BITS-1:0] y_first;
        logic signed [COORD_BITS-1:0] x_second;
        logic signed [COORD_BITS-1:0] y_second;
        logic signed [COORD_BITS-1:0] x_third;
        logic signed [COORD_BITS-1:0] y_third;
    } t_in;

    typedef struct packed {
        t_status             status;
        logic [AREA_W-1:0]   area;
    } t_out;

    // Per-triangle front-end results handed to both back-end paths.
    typedef struct packed {
        logic [2:0][MAG_W-1:0] dx_mag;
        logic [2:0][MAG_W-1:0] dy_mag;
        logic [2:0]            dx_zero;
        logic [2:0]            quo_neg;
        logic [1:0]            pair_cnt;
    } t_front;

endpackage

// ===== design/triangle_check_and_area.sv =====
// Triangle check and Heron area. Each request carries three vertices in signed Q8.8 and
// returns a status (valid, two vertices coincide, all coincide, collinear) and, for a valid
// triangle, the area as unsigned Q16.8 (zero otherwise). The pipeline takes one request per
// clock while the input is not stalled; the depth is set by the bit-per-stage square roots
// (17 stages for the sides, 38 for the final root) in series with the Heron multiply stages.
// The collinearity dividers (33 stages) run alongside. A two-entry output register holds one
// extra result during a downstream stall, so the input stalls only while both entries are
// full. The slope tolerance register takes a write on any cycle; write it while no request
// is in flight.
`include "triangle_check_and_area_defines.svh"

module triangle_check_and_area #(
    parameter int FRAC_BITS = tca_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  tca_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output tca_pkg::t_out               o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tca_pkg::TOL_W-1:0]   i_cfg_data
);
    import tca_pkg::*;

    localparam int SL_LAT = QUO_W + 2;
    localparam int HL_LAT = 1 + SIDE_W + 1 + 3 + ROOT_W + 1;
    localparam int VL     = 2 + HL_LAT;

    logic              w_en;
    logic [TOL_W-1:0]  r_tol;
    logic [VL-1:0]     r_vld;
    t_in               r_in;
    t_front            n_front, r_front;
    logic              r_out_valid, r_skid_valid;
    t_out              r_out, r_skid;

    assign w_en        = !r_skid_valid;
    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[VL-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in    <= i_in_data;
            r_front <= n_front;
        end
    end

    // Difference vectors: P1-P2, P1-P3, P2-P3.
    logic signed [MAG_W-1:0] w_dx [3];
    logic signed [MAG_W-1:0] w_dy [3];
    logic                    w_e01, w_e02, w_e12;

    assign w_dx[0] = $signed({r_in.x_first[COORD_BITS-1], r_in.x_first})
                   - $signed({r_in.x_second[COORD_BITS-1], r_in.x_second});
    assign w_dx[1] = $signed({r_in.x_first[COORD_BITS-1], r_in.x_first})
                   - $signed({r_in.x_third[COORD_BITS-1], r_in.x_third});
    assign w_dx[2] = $signed({r_in.x_second[COORD_BITS-1], r_in.x_second})
                   - $signed({r_in.x_third[COORD_BITS-1], r_in.x_third});
    assign w_dy[0] = $signed({r_in.y_first[COORD_BITS-1], r_in.y_first})
                   - $signed({r_in.y_second[COORD_BITS-1], r_in.y_second});
    assign w_dy[1] = $signed({r_in.y_first[COORD_BITS-1], r_in.y_first})
                   - $signed({r_in.y_third[COORD_BITS-1], r_in.y_third});
    assign w_dy[2] = $signed({r_in.y_second[COORD_BITS-1], r_in.y_second})
                   - $signed({r_in.y_third[COORD_BITS-1], r_in.y_third});

    assign w_e01 = (r_in.x_first == r_in.x_second) && (r_in.y_first == r_in.y_second);
    assign w_e02 = (r_in.x_first == r_in.x_third) && (r_in.y_first == r_in.y_third);
    assign w_e12 = (r_in.x_second == r_in.x_third) && (r_in.y_second == r_in.y_third);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_front.dx_mag[k]  = w_dx[k][MAG_W-1] ? MAG_W'(-w_dx[k]) : MAG_W'(w_dx[k]);
            n_front.dy_mag[k]  = w_dy[k][MAG_W-1] ? MAG_W'(-w_dy[k]) : MAG_W'(w_dy[k]);
            n_front.dx_zero[k] = (w_dx[k] == '0);
            n_front.quo_neg[k] = w_dx[k][MAG_W-1] ^ w_dy[k][MAG_W-1];
        end
        // first vertex's pairs win; count reaches 2 only when all coincide
        if (w_e01 || w_e02) begin
            n_front.pair_cnt = {w_e01 & w_e02, w_e01 ^ w_e02};
        end else begin
            n_front.pair_cnt = {1'b0, w_e12};
        end
    end

    t_status           w_stat_early;
    logic [1:0]        w_stat_bits;
    t_status           w_stat;
    logic [AREA_W-1:0] w_area;

    tca_slope u_slope (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_front  (r_front),
        .i_tol    (r_tol),
        .o_status (w_stat_early)
    );

    tca_delay #(
        .W (2),
        .N (HL_LAT - SL_LAT)
    ) u_stat_dly (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data (w_stat_early),
        .o_data (w_stat_bits)
    );

    assign w_stat = t_status'(w_stat_bits);

    tca_heron #(
        .FRAC_BITS (FRAC_BITS)
    ) u_heron (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_front (r_front),
        .o_area  (w_area)
    );

    t_out w_tail;
    logic w_tail_v;

    assign w_tail_v      = r_vld[VL-1];
    assign w_tail.status = w_stat;
    assign w_tail.area   = (w_stat == ST_VALID) ? w_area : '0;

    // Output register plus skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_tail_v;
            end
        end else if (w_en && w_tail_v) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            r_out <= r_skid_valid ? r_skid : w_tail;
        end else if (w_en && w_tail_v) begin
            r_skid <= w_tail;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `TCA_ASSERT_SAME(a_skid_needs_out, r_skid_valid, r_out_valid, "skid full with output empty")
    `TCA_ASSERT_NEXT(a_skid_catch, r_out_valid && i_out_stall && w_tail_v && !r_skid_valid, r_skid_valid, "stalled result not caught in skid")
    `TCA_ASSERT_NEXT(a_skid_drain, r_skid_valid && !i_out_stall, r_out_valid && !r_skid_valid, "skid not drained")
    `TCA_ASSERT_SAME(a_area_zero, o_out_valid && (o_out_data.status != ST_VALID), o_out_data.area == '0, "nonzero area on rejected triangle")

endmodule

// ===== design/tca_delay.sv =====
module tca_delay #(
    parameter int W = 8,
    parameter int N = 4
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data
);
    if (N == 0) begin : g_none
        assign o_data = i_data;
    end else begin : g_line
        logic [W-1:0] r_pipe [N];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pipe[0] <= i_data;
                for (int s = 1; s < N; s++) begin
                    r_pipe[s] <= r_pipe[s-1];
                end
            end
        end

        assign o_data = r_pipe[N-1];
    end
endmodule

// ===== design/tca_div.sv =====
module tca_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 17
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);
    // Restoring division, one quotient bit per stage.
    logic [NUM_W-1:0] r_nq  [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [NUM_W-1:0] p_nq;
        logic [DEN_W-1:0] p_rem;
        logic [DEN_W-1:0] p_den;
        logic [DEN_W:0]   rem_sh;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (s == 0) begin : g_first
            assign p_nq  = i_num;
            assign p_rem = '0;
            assign p_den = i_den;
        end else begin : g_next
            assign p_nq  = r_nq[s-1];
            assign p_rem = r_rem[s-1];
            assign p_den = r_den[s-1];
        end

        assign rem_sh = {p_rem, p_nq[NUM_W-1]};
        assign diff   = rem_sh - {1'b0, p_den};
        assign ge     = rem_sh >= {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[s]  <= {p_nq[NUM_W-2:0], ge};
                r_rem[s] <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                r_den[s] <= p_den;
            end
        end
    end

    assign o_quo = r_nq[NUM_W-1];
endmodule

// ===== design/tca_sqrt.sv =====
module tca_sqrt #(
    parameter int IN_W = 34
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [IN_W-1:0]     i_val,
    output logic [IN_W/2-1:0]   o_root
);
    localparam int OUT_W = IN_W / 2;
    localparam int REM_W = OUT_W + 3;

    // Digit-by-digit floor square root, one root bit per stage.
    logic [REM_W-1:0] r_rem  [OUT_W];
    logic [OUT_W-1:0] r_root [OUT_W];
    logic [IN_W-1:0]  r_x    [OUT_W];

    for (genvar s = 0; s < OUT_W; s++) begin : g_stage
        logic [REM_W-1:0] p_rem;
        logic [OUT_W-1:0] p_root;
        logic [IN_W-1:0]  p_x;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             ge;

        if (s == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_x    = i_val;
        end else begin : g_next
            assign p_rem  = r_rem[s-1];
            assign p_root = r_root[s-1];
            assign p_x    = r_x[s-1];
        end

        assign rem_sh = {p_rem[REM_W-3:0], p_x[IN_W-1 -: 2]};
        assign trial  = REM_W'({p_root, 2'b01});
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= ge ? rem_sh - trial : rem_sh;
                r_root[s] <= {p_root[OUT_W-2:0], ge};
                r_x[s]    <= {p_x[IN_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[OUT_W-1];
endmodule

// ===== design/tca_slope.sv =====
module tca_slope (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  tca_pkg::t_front             i_front,
    input  logic [tca_pkg::TOL_W-1:0]   i_tol,
    output tca_pkg::t_status            o_status
);
    import tca_pkg::*;

    localparam int SQ_QW = QUO_W + 1;
    localparam int SD_W  = QUO_W + 2;
    localparam int FL_W  = 8;

    logic [QUO_W-1:0] w_quo [3];
    logic [FL_W-1:0]  w_flags;

    for (genvar k = 0; k < 3; k++) begin : g_div
        tca_div #(
            .NUM_W (QUO_W),
            .DEN_W (MAG_W)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_num ({i_front.dy_mag[k], {SLOPE_FRAC{1'b0}}}),
            .i_den (i_front.dx_mag[k]),
            .o_quo (w_quo[k])
        );
    end

    tca_delay #(
        .W (FL_W),
        .N (QUO_W)
    ) u_flags (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_data ({i_front.pair_cnt, i_front.dx_zero, i_front.quo_neg}),
        .o_data (w_flags)
    );

    logic signed [SQ_QW-1:0] w_sq [3];
    logic signed [SD_W-1:0]  r_d1, r_d2;
    logic [1:0]              r_pair;
    logic [2:0]              r_zero;

    for (genvar k = 0; k < 3; k++) begin : g_sign
        assign w_sq[k] = w_flags[k] ? -$signed({1'b0, w_quo[k]}) : $signed({1'b0, w_quo[k]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1   <= SD_W'(w_sq[1]) - SD_W'(w_sq[0]);
            r_d2   <= SD_W'(w_sq[2]) - SD_W'(w_sq[0]);
            r_pair <= w_flags[7:6];
            r_zero <= w_flags[5:3];
        end
    end

    logic [SD_W-1:0] w_a1, w_a2;
    logic            w_line;
    t_status         n_status;
    t_status         r_status;

    assign w_a1 = r_d1[SD_W-1] ? SD_W'(-r_d1) : SD_W'(r_d1);
    assign w_a2 = r_d2[SD_W-1] ? SD_W'(-r_d2) : SD_W'(r_d2);

    always_comb begin
        if (r_zero[0]) begin
            w_line = r_zero[1] && r_zero[2];
        end else begin
            w_line = !r_zero[1] && !r_zero[2]
                  && (w_a1 <= SD_W'(i_tol)) && (w_a2 <= SD_W'(i_tol));
        end
        case (r_pair)
            2'd1:    n_status = ST_PAIR;
            2'd2:    n_status = ST_ALL;
            default: n_status = w_line ? ST_LINE : ST_VALID;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_status <= n_status;
        end
    end

    assign o_status = r_status;
endmodule

// ===== design/tca_heron.sv =====
module tca_heron #(
    parameter int FRAC_BITS = tca_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  tca_pkg::t_front              i_front,
    output logic [tca_pkg::AREA_W-1:0]   o_area
);
    import tca_pkg::*;

    localparam int SH   = 2 * FRAC_BITS + 2 - AREA_FRAC;
    localparam int LSH  = (SH < 0) ? -SH : 0;
    localparam int RSH  = (SH < 0) ? 0 : SH;
    localparam int WA_W = ROOT_W + LSH;

    // Squared side lengths.
    logic [SQ_W-1:0] r_sq [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= SQ_W'(i_front.dx_mag[k] * i_front.dx_mag[k])
                         + SQ_W'(i_front.dy_mag[k] * i_front.dy_mag[k]);
            end
        end
    end

    logic [SIDE_W-1:0] w_side [3];

    for (genvar k = 0; k < 3; k++) begin : g_side
        tca_sqrt #(
            .IN_W (SQ_W)
        ) u_sqrt (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_val  (r_sq[k]),
            .o_root (w_side[k])
        );
    end

    // Heron terms: perimeter and perimeter minus twice each side.
    logic [TERM_W-1:0] w_t0;
    logic [TERM_W-1:0] w_dbl [3];
    logic [TERM_W-1:0] r_t [4];

    assign w_t0 = TERM_W'(w_side[0]) + TERM_W'(w_side[1]) + TERM_W'(w_side[2]);

    for (genvar k = 0; k < 3; k++) begin : g_dbl
        assign w_dbl[k] = TERM_W'({w_side[k], 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t[0] <= w_t0;
            for (int k = 0; k < 3; k++) begin
                r_t[k+1] <= (w_dbl[k] <= w_t0) ? w_t0 - w_dbl[k] : '0;
            end
        end
    end

    logic [P2_W-1:0]   r_p01, r_p23;
    logic [PA_W-1:0]   r_pa, r_pb;
    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p01  <= P2_W'(r_t[0]) * P2_W'(r_t[1]);
            r_p23  <= P2_W'(r_t[2]) * P2_W'(r_t[3]);
            r_pa   <= PA_W'(r_p01) * PA_W'(r_p23[TERM_W-1:0]);
            r_pb   <= PA_W'(r_p01) * PA_W'(r_p23[P2_W-1:TERM_W]);
            r_prod <= PROD_W'(r_pa) + (PROD_W'(r_pb) << TERM_W);
        end
    end

    logic [ROOT_W-1:0] w_root;

    tca_sqrt #(
        .IN_W (PROD_W)
    ) u_root (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_val  (r_prod),
        .o_root (w_root)
    );

    // Root is 4*area with 2*FRAC_BITS fraction bits.
    logic [WA_W-1:0]   w_scaled;
    logic [AREA_W-1:0] r_area;

    assign w_scaled = (WA_W'(w_root) << LSH) >> RSH;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_area <= (w_scaled > WA_W'(AREA_MAX)) ? AREA_MAX : w_scaled[AREA_W-1:0];
        end
    end

    assign o_area = r_area;
endmodule

// ===== sim/tb_triangle_check_and_area.sv =====
module tb_triangle_check_and_area;
    import tca_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in                  i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out                 o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [TOL_W-1:0]     i_cfg_data;

    int error_count;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;

    class triangle_scoreboard;
        t_out             pending[$];
        logic [TOL_W-1:0] tolerance;

        function new();
            tolerance = '0;
        endfunction

        function automatic logic [63:0] isqrt(logic [127:0] n);
            logic [63:0]  r;
            logic [63:0]  c;
            logic [127:0] sq;
            r = '0;
            for (int b = 63; b >= 0; b--) begin
                c = r | (64'd1 << b);
                sq = {64'd0, c} * {64'd0, c};
                if (sq <= n) r = c;
            end
            return r;
        endfunction

        function automatic longint slope(longint dy, longint dx);
            longint q;
            q = ((dy < 0 ? -dy : dy) <<< SLOPE_FRAC) / (dx < 0 ? -dx : dx);
            return ((dy < 0) != (dx < 0)) ? -q : q;
        endfunction

        function automatic t_out predict(t_in req);
            longint       x[3], y[3], dx[3], dy[3];
            longint       q0, dq;
            logic [63:0]  sd[3], t[4];
            logic [127:0] p;
            logic [63:0]  r;
            int           overlaps;
            bit           aligned;
            t_out         res;
            x[0] = req.x_first;  y[0] = req.y_first;
            x[1] = req.x_second; y[1] = req.y_second;
            x[2] = req.x_third;  y[2] = req.y_third;
            overlaps = 0;
            if (x[0] == x[1] && y[0] == y[1]) overlaps++;
            if (x[0] == x[2] && y[0] == y[2]) overlaps++;
            if (overlaps == 0 && x[1] == x[2] && y[1] == y[2]) overlaps = 1;
            dx[0] = x[0] - x[1]; dy[0] = y[0] - y[1];
            dx[1] = x[0] - x[2]; dy[1] = y[0] - y[2];
            dx[2] = x[1] - x[2]; dy[2] = y[1] - y[2];
            res.area = '0;
            if (overlaps == 2) begin
                res.status = ST_ALL;
            end else if (overlaps == 1) begin
                res.status = ST_PAIR;
            end else begin
                aligned = 1;
                if (dx[0] == 0) begin
                    aligned = (dx[1] == 0 && dx[2] == 0);
                end else begin
                    q0 = slope(dy[0], dx[0]);
                    for (int k = 1; k < 3; k++) begin
                        if (aligned) begin
                            if (dx[k] == 0) begin
                                aligned = 0;
                            end else begin
                                dq = q0 - slope(dy[k], dx[k]);
                                if (dq < 0) dq = -dq;
                                if (dq > longint'(tolerance)) aligned = 0;
                            end
                        end
                    end
                end
                res.status = aligned ? ST_LINE : ST_VALID;
            end
            if (res.status == ST_VALID) begin
                for (int k = 0; k < 3; k++)
                    sd[k] = isqrt(128'(dx[k] * dx[k]) + 128'(dy[k] * dy[k]));
                t[0] = sd[0] + sd[1] + sd[2];
                for (int k = 0; k < 3; k++)
                    t[k+1] = (2 * sd[k] <= t[0]) ? t[0] - 2 * sd[k] : 64'd0;
                p = 128'(t[0]) * 128'(t[1]) * 128'(t[2]) * 128'(t[3]);
                r = isqrt(p) >> (2 * FRAC_BITS_DEF + 2 - AREA_FRAC);
                res.area = (r > 64'(AREA_MAX)) ? AREA_MAX : r[AREA_W-1:0];
            end
            return res;
        endfunction

        function void note_request(t_in req);
            pending.push_back(predict(req));
        endfunction

        function bit check_result(t_out got, output string msg);
            t_out want;
            if (pending.size() == 0) begin
                msg = $sformatf("unexpected result status=%0d area=%0h", got.status, got.area);
                return 0;
            end
            want = pending.pop_front();
            msg = "";
            if (got.status != want.status)
                msg = $sformatf("status got %0d want %0d", got.status, want.status);
            if (got.area != want.area)
                msg = {msg, $sformatf(" area got %0h want %0h", got.area, want.area)};
            return msg == "";
        endfunction
    endclass

    triangle_scoreboard sb;

    triangle_check_and_area DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // result side: check, then pick next stall
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_out_valid && !i_out_stall)
            if (!sb.check_result(o_out_data, msg)) report_mismatch(msg);
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_triangle(t_in req);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(req);
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            i_in_data  <= t_in'({$urandom, $urandom, $urandom});
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] tol);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= tol;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.tolerance = tol;
    endtask

    function automatic t_in make_tri(int ax, int ay, int bx, int by, int cx, int cy);
        t_in t;
        t.x_first  = 16'(ax); t.y_first  = 16'(ay);
        t.x_second = 16'(bx); t.y_second = 16'(by);
        t.x_third  = 16'(cx); t.y_third  = 16'(cy);
        return t;
    endfunction

    function automatic t_in random_triangle();
        int ax, ay, dx, dy, k1, k2, mode;
        mode = $urandom_range(99);
        if (mode < 40) return t_in'({$urandom, $urandom, $urandom});
        ax = $signed($urandom_range(20000)) - 10000;
        ay = $signed($urandom_range(20000)) - 10000;
        dx = $signed($urandom_range(400)) - 200;
        dy = $signed($urandom_range(400)) - 200;
        k1 = $signed($urandom_range(40)) - 20;
        k2 = $signed($urandom_range(40)) - 20;
        if (mode < 65)
            return make_tri(ax, ay, ax + k1 * dx, ay + k1 * dy, ax + k2 * dx,
                            ay + k2 * dy + ($signed($urandom_range(2)) - 1));
        if (mode < 75)
            return make_tri(ax, ay, ax + dx, ay + dy, ax, ay + dy * $urandom_range(1));
        if (mode < 80)
            return make_tri(ax, ay, ax, ay, ax + dx, ay + dy);
        if (mode < 85)
            return make_tri(ax, ay, ax, ay + k1, ax, ay + k2);
        return make_tri(ax, ay, ax + dx, ay + k1, ax + k2, ay + dy);
    endfunction

    initial begin
        t_in directed[$];
        sb = new();
        error_count  = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        quiet_cycles = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_stall  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(make_tri(0, 0, 768, 0, 0, 1024));
        directed.push_back(make_tri(5, 5, 5, 5, 5, 5));
        directed.push_back(make_tri(5, 5, 5, 5, 9, 1));
        directed.push_back(make_tri(5, 5, 9, 1, 5, 5));
        directed.push_back(make_tri(9, 1, 5, 5, 5, 5));
        directed.push_back(make_tri(7, 0, 7, 300, 7, -900));
        directed.push_back(make_tri(7, 0, 7, 300, 8, -900));
        directed.push_back(make_tri(7, 0, 8, 300, 7, -900));
        directed.push_back(make_tri(-100, 3, 200, 3, 900, 3));
        directed.push_back(make_tri(0, 0, 256, 256, 512, 512));
        directed.push_back(make_tri(0, 0, 300, 100, 601, 200));
        directed.push_back(make_tri(0, 0, 3, 1, 7, 2));
        directed.push_back(make_tri(-32768, -32768, 32767, -32768, -32768, 32767));
        directed.push_back(make_tri(32767, 32767, -32768, 32767, 32767, -32768));
        directed.push_back(make_tri(-32768, 32767, 32767, -32768, 32767, 32767));
        directed.push_back(make_tri(-32768, -32768, 32767, 32767, -32768, 32767));
        directed.push_back(make_tri(0, 0, 1, 0, 0, 1));
        directed.push_back(make_tri(-1, -1, 1, 0, 0, 1));
        directed.push_back(make_tri(-32768, 0, 32767, 1, 0, -32768));

        for (int pass = 0; pass < 2; pass++) begin
            write_tolerance(pass == 0 ? 16'd0 : 16'hFFFF);
            foreach (directed[i]) send_triangle(directed[i]);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 73; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            case (phase)
                0: write_tolerance(16'd0);
                1: write_tolerance(16'($urandom_range(2000)));
                2: write_tolerance(16'hFFFF);
                default: write_tolerance(16'($urandom));
            endcase
            for (int n = 0; n < 110; n++) send_triangle(random_triangle());
        end

        wait_drained();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/tca_pkg.sv
design/tca_delay.sv
design/tca_div.sv
design/tca_sqrt.sv
design/tca_slope.sv
design/tca_heron.sv
design/triangle_check_and_area.sv
sim/tb_triangle_check_and_area.sv
